// ===== sv/write_reuse_distance_histogram_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the write reuse-distance histogram
// Expect signals named clk and arst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef WRITE_REUSE_DISTANCE_HISTOGRAM_ASSERT_SVH
`define WRITE_REUSE_DISTANCE_HISTOGRAM_ASSERT_SVH

`ifndef SYNTH
`define WRDH_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("%m: check failed");
`define WRDH_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("%m: check failed");
`else
`define WRDH_ASSERT_IMPL(name, pre, post)
`define WRDH_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== sv/wrdh_pkg.sv =====
// ----------------------------------------------------------------------------
// wrdh_pkg
// Sizes, field widths and inter-module bundles of the reuse-distance histogram.
// ----------------------------------------------------------------------------
package wrdh_pkg;

	localparam int NUM_BLOCKS     = 65536;
	localparam int HIST_BINS      = 8192;
	localparam int DIST_UNIT      = 4096;	// power of two
	localparam int MAX_REQ_BLOCKS = 256;

	localparam int BLK_BYTES  = 4096;
	localparam int BLK_SHIFT  = $clog2(BLK_BYTES);
	localparam int DIST_SHIFT = $clog2(DIST_UNIT);

	localparam int ID_W    = 48;
	localparam int COUNT_W = 48;
	localparam int BLK_AW  = $clog2(NUM_BLOCKS);
	localparam int BIN_AW  = $clog2(HIST_BINS);
	localparam int NBLK_W  = $clog2(MAX_REQ_BLOCKS + 2);

	// clear sweep covers the larger of the two stores
	localparam int CLR_N = (NUM_BLOCKS > HIST_BINS) ? NUM_BLOCKS : HIST_BINS;
	localparam int CLR_W = $clog2(CLR_N);

	localparam int OFF_W      = 28;
	localparam int LEN_W      = 21;
	localparam int TS_W       = 64;
	localparam int BINIDX_W   = 13;
	localparam int STATUS_W   = 2;
	localparam int RW_W       = 9;
	localparam int BEGIN_W    = 35;
	localparam int WMIN_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 35;

	typedef struct packed {
		logic [BEGIN_W-1:0] begin_minute;
		logic               window_enable;
		logic [WMIN_W-1:0]  window_minutes;
	} cfg_t;

	typedef struct packed {
		logic             active;
		logic [CLR_W-1:0] addr;
	} clr_t;

	typedef struct packed {
		logic              valid;
		logic [BLK_AW-1:0] blk;
		logic [ID_W-1:0]   id;
	} blk_req_t;

	typedef struct packed {
		logic              valid;
		logic [BIN_AW-1:0] bin;
	} hist_upd_t;

	typedef struct packed {
		logic              valid;
		logic [BIN_AW-1:0] bin;
	} hist_rd_t;

	typedef struct packed {
		logic done;
		logic outside;
	} win_res_t;

endpackage

// ===== sv/wrdh_window.sv =====
// ----------------------------------------------------------------------------
// wrdh_window
// Time window check in four stages. Minute bounds are scaled to tick bounds
// with split multiplies, so no division of the timestamp is needed.
// ----------------------------------------------------------------------------
module wrdh_window (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  wrdh_pkg::cfg_t           cfg,
	input  logic [wrdh_pkg::TS_W-1:0] ts,
	output wrdh_pkg::win_res_t       res
);
	import wrdh_pkg::*;

	localparam logic [29:0] TICKS_PER_MIN = 30'd600000000;
	localparam int SPLIT  = 18;
	localparam int PROD_W = 48;
	localparam int TICK_W = 66;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [BEGIN_W:0]   hi_min_s1;
	logic [PROD_W-1:0]  plo0_s1, plo1_s1;
	logic [TICK_W-1:0]  lo_s2;
	logic [PROD_W-1:0]  phi0_s2, phi1_s2;
	logic [TICK_W-1:0]  hi_s3;
	logic               below_s3;
	logic               outside_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// outside when the window is enabled and ts < begin*T or ts >= (begin+window)*T
	always_ff @(posedge clk) begin
		hi_min_s1 <= (BEGIN_W+1)'(cfg.begin_minute) + (BEGIN_W+1)'(cfg.window_minutes);
		plo0_s1   <= PROD_W'(cfg.begin_minute[SPLIT-1:0]) * PROD_W'(TICKS_PER_MIN);
		plo1_s1   <= PROD_W'(cfg.begin_minute[BEGIN_W-1:SPLIT]) * PROD_W'(TICKS_PER_MIN);

		lo_s2   <= TICK_W'(plo0_s1) + (TICK_W'(plo1_s1) << SPLIT);
		phi0_s2 <= PROD_W'(hi_min_s1[SPLIT-1:0]) * PROD_W'(TICKS_PER_MIN);
		phi1_s2 <= PROD_W'(hi_min_s1[BEGIN_W:SPLIT]) * PROD_W'(TICKS_PER_MIN);

		hi_s3    <= TICK_W'(phi0_s2) + (TICK_W'(phi1_s2) << SPLIT);
		below_s3 <= TICK_W'(ts) < lo_s2;

		outside_s4 <= cfg.window_enable && (below_s3 || (TICK_W'(ts) >= hi_s3));
	end

	assign res.done    = v_s4;
	assign res.outside = outside_s4;

endmodule

// ===== sv/wrdh_lastwr.sv =====
// ----------------------------------------------------------------------------
// wrdh_lastwr
// Last-write id store. Reads the old id and writes the new one in the same
// cycle, then turns the id distance into a histogram bin.
// ----------------------------------------------------------------------------
module wrdh_lastwr (
	input  logic                clk,
	input  logic                arst_n,
	input  wrdh_pkg::clr_t      clr,
	input  wrdh_pkg::blk_req_t  req,
	output wrdh_pkg::hist_upd_t upd,
	output logic                busy
);
	import wrdh_pkg::*;

	localparam int DQ_W = ID_W - DIST_SHIFT;

	logic [ID_W-1:0] lw_mem [NUM_BLOCKS];

	logic [ID_W-1:0]   prev_s1, id_s1;
	logic              vld_s1;
	hist_upd_t         upd_s2;
	logic [ID_W-1:0]   id_gap;
	logic [DQ_W-1:0]   dq;
	logic [BIN_AW-1:0] bin;
	logic              clr_hit;

	assign clr_hit = clr.active && ((CLR_W+1)'(clr.addr) < (CLR_W+1)'(NUM_BLOCKS));

	// read returns the old id when the same block is written in this cycle
	always_ff @(posedge clk) begin
		if (clr_hit) begin
			lw_mem[clr.addr[BLK_AW-1:0]] <= '0;
		end else if (req.valid) begin
			lw_mem[req.blk] <= req.id;
		end
		prev_s1 <= lw_mem[req.blk];
		id_s1   <= req.id;
	end

	assign id_gap = id_s1 - prev_s1;
	assign dq     = id_gap[ID_W-1:DIST_SHIFT];
	assign bin    = (dq > DQ_W'(HIST_BINS - 1)) ? BIN_AW'(HIST_BINS - 1) : BIN_AW'(dq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			upd_s2 <= '0;
		end else begin
			vld_s1       <= req.valid;
			upd_s2.valid <= vld_s1 && (prev_s1 != '0);	// zero id: never written
			upd_s2.bin   <= bin;
		end
	end

	assign upd  = upd_s2;
	assign busy = vld_s1;

endmodule

// ===== sv/wrdh_hist.sv =====
// ----------------------------------------------------------------------------
// wrdh_hist
// Histogram store with a read-increment-write pipe and one-deep forwarding
// of the write that lands on the same edge as the next read.
// ----------------------------------------------------------------------------
`include "write_reuse_distance_histogram_assert.svh"

module wrdh_hist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wrdh_pkg::clr_t               clr,
	input  wrdh_pkg::hist_upd_t          upd,
	input  wrdh_pkg::hist_rd_t           rd,
	output logic [wrdh_pkg::COUNT_W-1:0] rd_data,
	output logic                         busy
);
	import wrdh_pkg::*;

	logic [COUNT_W-1:0] hist_mem [HIST_BINS];

	logic [BIN_AW-1:0]  raddr;
	logic [COUNT_W-1:0] rd_q;
	logic               vld_s3;
	logic [BIN_AW-1:0]  bin_s3;
	logic               wr_vld_q;
	logic [BIN_AW-1:0]  wr_bin_q;
	logic [COUNT_W-1:0] wr_val_q;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W-1:0] incr;
	logic               clr_hit;

	assign clr_hit = clr.active && ((CLR_W+1)'(clr.addr) < (CLR_W+1)'(HIST_BINS));
	assign raddr   = rd.valid ? rd.bin : upd.bin;

	always_ff @(posedge clk) begin
		if (clr_hit) begin
			hist_mem[clr.addr[BIN_AW-1:0]] <= '0;
		end else if (vld_s3) begin
			hist_mem[bin_s3] <= incr;
		end
		rd_q <= hist_mem[raddr];
	end

	// previous write hit the memory on the same edge as this read
	assign base = (wr_vld_q && (wr_bin_q == bin_s3)) ? wr_val_q : rd_q;
	assign incr = base + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3   <= 1'b0;
			bin_s3   <= '0;
			wr_vld_q <= 1'b0;
			wr_bin_q <= '0;
			wr_val_q <= '0;
		end else begin
			vld_s3   <= upd.valid;
			bin_s3   <= upd.bin;
			wr_vld_q <= vld_s3;
			wr_bin_q <= bin_s3;
			wr_val_q <= incr;
		end
	end

	assign rd_data = rd_q;
	assign busy    = vld_s3;

	`WRDH_ASSERT_IMPL(a_rd_no_update, rd.valid, !upd.valid && !vld_s3)
	`WRDH_ASSERT_IMPL(a_clr_no_update, clr.active, !upd.valid && !vld_s3 && !rd.valid)
	`WRDH_ASSERT_NEXT(a_fwd_tracks_write, vld_s3, wr_vld_q && (wr_val_q != '0))

endmodule

// ===== sv/write_reuse_distance_histogram.sv =====
// Histogram read: the bin is read in S_HRD, captured in S_HCAP, returned from S_FIN.
// Request without block walk (window, not write, range): the result follows the window check.
// Write request over N blocks: one block per cycle, then the result once the last
// histogram update has drained; req_stall drops as the result is presented.
// After reset a clearing pass over all 65536 addresses zeroes both stores; req_stall
// is high during it, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// write_reuse_distance_histogram
// Reuse-distance histogram of written 4 KiB blocks, top level and sequencer.
// ----------------------------------------------------------------------------
`include "write_reuse_distance_histogram_assert.svh"

module write_reuse_distance_histogram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wrdh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wrdh_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             cmd,
	input  logic                             is_write,
	input  logic [wrdh_pkg::OFF_W-1:0]       offset_bytes,
	input  logic [wrdh_pkg::LEN_W-1:0]       length_bytes,
	input  logic [wrdh_pkg::TS_W-1:0]        timestamp,
	input  logic [wrdh_pkg::BINIDX_W-1:0]    bin_index,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [wrdh_pkg::STATUS_W-1:0]    status,
	output logic [wrdh_pkg::RW_W-1:0]        rewrites,
	output logic [wrdh_pkg::COUNT_W-1:0]     bin_count
);
	import wrdh_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_WIN, S_WALK, S_DRAIN, S_HRD, S_HCAP, S_FIN
	} state_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE, ST_WINDOW, ST_RANGE, ST_NOWRITE
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BEGIN, CFG_WEN, CFG_WMIN
	} cfg_reg_t;

	localparam int SPAN_W  = OFF_W + 1;
	localparam int STOP_W  = SPAN_W + 1 - BLK_SHIFT;
	localparam int FIRST_W = OFF_W - BLK_SHIFT;
	localparam logic [63:0] MAX_REQ_BYTES = 64'(MAX_REQ_BLOCKS) * 64'(BLK_BYTES);
	localparam logic [63:0] SPAN_LIMIT    = 64'(NUM_BLOCKS) * 64'(BLK_BYTES);
	localparam logic [BEGIN_W-1:0] BEGIN_RST = BEGIN_W'(213610620);
	localparam logic [WMIN_W-1:0]  WMIN_RST  = WMIN_W'(10080);

	state_t               state_q;
	cfg_t                 cfg_q;
	logic                 is_write_q;
	logic [OFF_W-1:0]     off_q;
	logic [LEN_W-1:0]     len_q;
	logic [TS_W-1:0]      ts_q;
	logic [BINIDX_W-1:0]  bin_q;
	logic [SPAN_W-1:0]    span_end_q;
	logic [NBLK_W-1:0]    nblk_q;
	logic                 range_bad_q;
	logic [BLK_AW-1:0]    blk_q;
	logic [NBLK_W-1:0]    remain_q;
	logic [ID_W-1:0]      next_id_q;
	logic [RW_W-1:0]      rw_q;
	logic [CLR_W-1:0]     clr_q;
	status_t              fin_status_q;
	logic [COUNT_W-1:0]   fin_count_q;
	logic                 rsp_valid_q;
	status_t              status_q;
	logic [RW_W-1:0]      rewrites_q;
	logic [COUNT_W-1:0]   bin_count_q;

	logic [SPAN_W:0]      span_sum;
	logic [STOP_W-1:0]    stop_blk;
	logic [FIRST_W-1:0]   first_blk;
	logic [STOP_W-1:0]    nblk_full;
	logic                 bin_ok;
	logic                 drained;
	logic                 out_free;
	logic                 lw_busy, hist_busy;
	logic [COUNT_W-1:0]   hist_rd_data;

	clr_t       clr;
	blk_req_t   blk_req;
	hist_upd_t  upd;
	hist_rd_t   hrd;
	win_res_t   win;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);

	assign clr.active    = (state_q == S_CLEAR);
	assign clr.addr      = clr_q;
	assign blk_req.valid = (state_q == S_WALK) && (remain_q != '0);
	assign blk_req.blk   = blk_q;
	assign blk_req.id    = next_id_q;
	assign hrd.valid     = (state_q == S_HRD);
	assign hrd.bin       = BIN_AW'(bin_q);

	// block span of a request: [off/4K, ceil((off+len)/4K))
	assign span_sum  = (SPAN_W+1)'(span_end_q) + (SPAN_W+1)'(BLK_BYTES - 1);
	assign stop_blk  = span_sum[SPAN_W:BLK_SHIFT];
	assign first_blk = off_q[OFF_W-1:BLK_SHIFT];
	assign nblk_full = stop_blk - STOP_W'(first_blk);

	assign bin_ok   = (32'(bin_q) < 32'(HIST_BINS));
	assign drained  = !lw_busy && !upd.valid && !hist_busy;
	assign out_free = !rsp_valid_q || !rsp_stall;

	wrdh_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_valid && !req_stall && !cmd),
		.cfg    (cfg_q),
		.ts     (ts_q),
		.res    (win)
	);

	wrdh_lastwr u_lastwr (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.req    (blk_req),
		.upd    (upd),
		.busy   (lw_busy)
	);

	wrdh_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.upd     (upd),
		.rd      (hrd),
		.rd_data (hist_rd_data),
		.busy    (hist_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cfg_q        <= '{begin_minute: BEGIN_RST, window_enable: 1'b0,
			                  window_minutes: WMIN_RST};
			is_write_q   <= 1'b0;
			off_q        <= '0;
			len_q        <= '0;
			ts_q         <= '0;
			bin_q        <= '0;
			span_end_q   <= '0;
			nblk_q       <= '0;
			range_bad_q  <= 1'b0;
			blk_q        <= '0;
			remain_q     <= '0;
			next_id_q    <= ID_W'(1);
			rw_q         <= '0;
			clr_q        <= '0;
			fin_status_q <= ST_DONE;
			fin_count_q  <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_DONE;
			rewrites_q   <= '0;
			bin_count_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BEGIN: cfg_q.begin_minute   <= cfg_data[BEGIN_W-1:0];
					CFG_WEN:   cfg_q.window_enable  <= cfg_data[0];
					CFG_WMIN:  cfg_q.window_minutes <= cfg_data[WMIN_W-1:0];
					default: ;
				endcase
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// span math settles while the window check runs
			span_end_q  <= SPAN_W'(off_q) + SPAN_W'(len_q);
			nblk_q      <= NBLK_W'(nblk_full);
			range_bad_q <= (64'(len_q) > MAX_REQ_BYTES) || (64'(span_end_q) > SPAN_LIMIT);

			if (upd.valid) begin
				rw_q <= rw_q + RW_W'(1);
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						is_write_q <= is_write;
						off_q      <= offset_bytes;
						len_q      <= length_bytes;
						ts_q       <= timestamp;
						bin_q      <= bin_index;
						rw_q       <= '0;
						state_q    <= cmd ? S_HRD : S_WIN;
					end
				end
				S_WIN: begin
					if (win.done) begin
						fin_count_q <= '0;
						if (win.outside) begin
							fin_status_q <= ST_WINDOW;
							state_q      <= S_FIN;
						end else if (!is_write_q) begin
							fin_status_q <= ST_NOWRITE;
							state_q      <= S_FIN;
						end else if (range_bad_q) begin
							fin_status_q <= ST_RANGE;
							state_q      <= S_FIN;
						end else begin
							fin_status_q <= ST_DONE;
							blk_q        <= BLK_AW'(first_blk);
							remain_q     <= nblk_q;
							state_q      <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (remain_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						blk_q     <= blk_q + BLK_AW'(1);
						remain_q  <= remain_q - NBLK_W'(1);
						next_id_q <= next_id_q + ID_W'(1);
					end
				end
				S_DRAIN: begin
					if (drained) begin
						state_q <= S_FIN;
					end
				end
				S_HRD: begin
					state_q <= S_HCAP;
				end
				S_HCAP: begin
					fin_status_q <= ST_DONE;
					fin_count_q  <= bin_ok ? hist_rd_data : '0;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						status_q    <= fin_status_q;
						rewrites_q  <= rw_q;
						bin_count_q <= fin_count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign rewrites  = rewrites_q;
	assign bin_count = bin_count_q;

	`WRDH_ASSERT_IMPL(a_idle_drained, state_q == S_IDLE, !lw_busy && !upd.valid && !hist_busy)
	`WRDH_ASSERT_NEXT(a_id_advances, blk_req.valid, next_id_q == $past(next_id_q) + ID_W'(1))
	`WRDH_ASSERT_IMPL(a_clear_quiet, clr.active, !blk_req.valid && !rsp_valid_q && !hrd.valid)

endmodule

// ===== tb/write_reuse_distance_histogram_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_reuse_distance_histogram_test
// Drives storage requests and bin reads into the reuse-distance histogram
// with random gaps and output stalls. A tracker keeps its own copy of the
// last-write store, sequence counter and histogram, predicts each result and
// compares it field by field. Several window settings are walked through.
// ----------------------------------------------------------------------------
module write_reuse_distance_histogram_test;

	import wrdh_pkg::*;

	typedef enum bit {CMD_REQUEST, CMD_READ_BIN} cmd_e;
	typedef enum bit [STATUS_W-1:0] {ST_DONE, ST_OUTSIDE, ST_RANGE, ST_NOT_WRITE} status_e;
	typedef enum bit [CFG_IDX_W-1:0] {
		REG_BEGIN_MINUTE, REG_WINDOW_ENABLE, REG_WINDOW_MINUTES
	} cfg_reg_e;

	localparam bit [63:0] TICKS_PER_MIN = 64'd600000000;
	localparam longint    LAST_MINUTE   = 64'd30744573456;
	localparam longint    RESET_BEGIN   = 64'd213610620;
	localparam int        RESET_WINDOW  = 10080;

	typedef struct packed {
		cmd_e                cmd;
		bit                  is_write;
		bit [OFF_W-1:0]      offset;
		bit [LEN_W-1:0]      len;
		bit [TS_W-1:0]       ts;
		bit [BINIDX_W-1:0]   bin;
	} req_t;

	typedef struct packed {
		bit [STATUS_W-1:0] status;
		bit [RW_W-1:0]     rewrites;
		bit [COUNT_W-1:0]  bin_count;
	} rsp_t;

	class reuse_tracker;
		bit [ID_W-1:0]    last_id [NUM_BLOCKS];
		bit [COUNT_W-1:0] hist [HIST_BINS];
		bit [ID_W-1:0]    next_id;
		bit [BEGIN_W-1:0] begin_min;
		bit               win_en;
		bit [WMIN_W-1:0]  win_len;
		rsp_t             pending_results[$];
		int               failures;
		int               printed;

		function new();
			next_id   = 1;
			begin_min = BEGIN_W'(RESET_BEGIN);
			win_en    = 1'b0;
			win_len   = WMIN_W'(RESET_WINDOW);
		endfunction

		function void set_register(cfg_reg_e idx, bit [CFG_DATA_W-1:0] value);
			case (idx)
				REG_BEGIN_MINUTE:   begin_min = value[BEGIN_W-1:0];
				REG_WINDOW_ENABLE:  win_en = value[0];
				REG_WINDOW_MINUTES: win_len = value[WMIN_W-1:0];
				default: ;
			endcase
		endfunction

		function bit skipped_by_window(bit [63:0] ts);
			bit [63:0] minute;
			minute = ts / TICKS_PER_MIN;
			if (!win_en)
				return 1'b0;
			if (minute < 64'(begin_min))
				return 1'b1;
			return (minute - 64'(begin_min)) >= 64'(win_len);
		endfunction

		function void take_request(req_t r);
			rsp_t          e;
			bit [63:0]     first;
			bit [63:0]     stop;
			bit [63:0]     b;
			bit [ID_W-1:0] prev;
			bit [ID_W-1:0] bucket;
			int            n;
			e = '0;
			n = 0;
			if (r.cmd == CMD_READ_BIN) begin
				if (32'(r.bin) < HIST_BINS)
					e.bin_count = hist[r.bin];
			end else if (skipped_by_window(r.ts)) begin
				e.status = ST_OUTSIDE;
			end else if (!r.is_write) begin
				e.status = ST_NOT_WRITE;
			end else begin
				first = 64'(r.offset) / 64'(BLK_BYTES);
				stop  = (64'(r.offset) + 64'(r.len) + 64'(BLK_BYTES - 1)) / 64'(BLK_BYTES);
				if (64'(r.len) > 64'(MAX_REQ_BLOCKS * BLK_BYTES) || stop > 64'(NUM_BLOCKS)) begin
					e.status = ST_RANGE;
				end else begin
					for (b = first; b < stop; b++) begin
						prev = last_id[b];
						if (prev != 0) begin
							// distance wraps at the id width
							bucket = (next_id - prev) / ID_W'(DIST_UNIT);
							if (bucket > ID_W'(HIST_BINS - 1))
								bucket = ID_W'(HIST_BINS - 1);
							hist[bucket] = hist[bucket] + COUNT_W'(1);
							n++;
						end
						last_id[b] = next_id;
						next_id = next_id + ID_W'(1);
					end
					e.rewrites = n[RW_W-1:0];
				end
			end
			pending_results.push_back(e);
		endfunction

		task report_mismatch(string msg);
			failures++;
			if (printed < 100) begin
				printed++;
				$display("%0t: mismatch: %s", $time, msg);
			end
		endtask

		task check_response(logic [STATUS_W-1:0] st, logic [RW_W-1:0] rw,
				logic [COUNT_W-1:0] cnt);
			rsp_t e;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no item outstanding");
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.status)
				report_mismatch($sformatf("status %0d, want %0d", st, e.status));
			if (rw !== e.rewrites)
				report_mismatch($sformatf("rewrites %0d, want %0d", rw, e.rewrites));
			if (cnt !== e.bin_count)
				report_mismatch($sformatf("bin_count %0d, want %0d", cnt, e.bin_count));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	logic                  cmd;
	logic                  is_write;
	logic [OFF_W-1:0]      offset_bytes;
	logic [LEN_W-1:0]      length_bytes;
	logic [TS_W-1:0]       timestamp;
	logic [BINIDX_W-1:0]   bin_index;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic [STATUS_W-1:0]   status;
	logic [RW_W-1:0]       rewrites;
	logic [COUNT_W-1:0]    bin_count;

	reuse_tracker tracker = new();
	bit           calm;
	longint       cur_begin;
	int unsigned  cur_wmin;

	write_reuse_distance_histogram i_dut (.*);

	always #6 clk = ~clk;

	function automatic int idle_length();
		int unsigned p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// stamp near the window edges so both sides of each bound get hit
	function automatic bit [63:0] near_window_stamp();
		longint      minute;
		longint      delta;
		int unsigned rem_max;
		int unsigned rem;
		delta = $urandom_range(0, 5);
		case ($urandom_range(0, 4))
			0: minute = cur_begin + delta - 3;
			1: minute = cur_begin + longint'(cur_wmin) + delta - 3;
			2: minute = cur_begin + longint'($urandom_range(0, cur_wmin));
			default: return {$urandom, $urandom};
		endcase
		if (minute < 0)
			minute = 0;
		if (minute > LAST_MINUTE)
			minute = LAST_MINUTE;
		rem_max = (minute == LAST_MINUTE) ? 109551615 : 599999999;
		case ($urandom_range(0, 2))
			0: rem = 0;
			1: rem = rem_max;
			default: rem = $urandom_range(0, rem_max);
		endcase
		return 64'(minute) * TICKS_PER_MIN + 64'(rem);
	endfunction

	function automatic req_t write_item(bit [OFF_W-1:0] off, bit [LEN_W-1:0] len);
		req_t r;
		r.cmd      = CMD_REQUEST;
		r.is_write = 1'b1;
		r.offset   = off;
		r.len      = len;
		r.ts       = {$urandom, $urandom};
		r.bin      = BINIDX_W'($urandom);
		return r;
	endfunction

	function automatic req_t read_item(bit [BINIDX_W-1:0] bin);
		req_t r;
		r        = write_item(OFF_W'($urandom), LEN_W'($urandom));
		r.cmd    = CMD_READ_BIN;
		r.is_write = 1'($urandom_range(0, 1));
		r.bin    = bin;
		return r;
	endfunction

	function automatic req_t random_item(bit windowed);
		req_t        r;
		int unsigned pick;
		int unsigned k;
		r = write_item(OFF_W'($urandom), LEN_W'($urandom));
		if (windowed)
			r.ts = near_window_stamp();
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			r.cmd = CMD_READ_BIN;
			r.bin = ($urandom_range(0, 3) == 0) ? BINIDX_W'($urandom)
				: BINIDX_W'($urandom_range(0, 3));
		end else if (pick < 17) begin
			r.is_write = 1'b0;
		end else if (pick < 22) begin
			if ($urandom_range(0, 1)) begin
				r.len = LEN_W'($urandom_range(MAX_REQ_BLOCKS * BLK_BYTES + 1, 2 ** LEN_W - 1));
			end else begin
				// span runs just past the top of the block store
				k = $urandom_range(1, 8192);
				r.offset = OFF_W'(NUM_BLOCKS * BLK_BYTES - k);
				r.len = LEN_W'(k + $urandom_range(1, 4096));
			end
		end else if (pick < 32) begin
			r.offset = OFF_W'($urandom_range(0, 1023) * BLK_BYTES);
			if ($urandom_range(0, 1))
				r.offset += OFF_W'($urandom_range(0, BLK_BYTES - 1));
			r.len = ($urandom_range(0, 3) == 0) ? LEN_W'(MAX_REQ_BLOCKS * BLK_BYTES)
				: LEN_W'($urandom_range(0, MAX_REQ_BLOCKS * BLK_BYTES));
		end else if (pick < 40) begin
			r.len = LEN_W'($urandom_range(0, 16383));
		end else begin
			// small rewrites over a hot set of blocks
			r.offset = OFF_W'($urandom_range(0, 63) * BLK_BYTES);
			if ($urandom_range(0, 1))
				r.offset += OFF_W'($urandom_range(0, BLK_BYTES - 1));
			r.len = LEN_W'($urandom_range(0, 3) * BLK_BYTES);
			if ($urandom_range(0, 1))
				r.len += LEN_W'($urandom_range(0, BLK_BYTES - 1));
		end
		return r;
	endfunction

	task send_request(req_t r);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd          <= r.cmd;
		is_write     <= r.is_write;
		offset_bytes <= r.offset;
		length_bytes <= r.len;
		timestamp    <= r.ts;
		bin_index    <= r.bin;
		req_valid    <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		tracker.take_request(r);
	endtask

	task wait_until_drained();
		req_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task write_register(cfg_reg_e idx, bit [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		tracker.set_register(idx, value);
	endtask

	task program_window(bit [BEGIN_W-1:0] begin_min, bit en, bit [WMIN_W-1:0] wmin);
		write_register(REG_BEGIN_MINUTE, begin_min);
		write_register(REG_WINDOW_ENABLE, CFG_DATA_W'(en));
		write_register(REG_WINDOW_MINUTES, CFG_DATA_W'(wmin));
		cfg_valid <= 1'b0;
		cur_begin = longint'(begin_min);
		cur_wmin  = 32'(wmin);
	endtask

	task run_phase(int items, bit windowed);
		for (int i = 0; i < items; i++) begin
			send_request(random_item(windowed));
			if (i % 60 == 59)
				wait_until_drained();
		end
		wait_until_drained();
	endtask

	initial begin
		int   hold;
		hold = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				tracker.check_response(status, rewrites, bin_count);
			if (hold > 0) begin
				hold--;
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 3) == 0);
				hold = idle_length();
			end
		end
	end

	initial begin
		req_t r;
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_BEGIN_MINUTE;
		cfg_data     <= '0;
		req_valid    <= 1'b0;
		cmd          <= CMD_REQUEST;
		is_write     <= 1'b0;
		offset_bytes <= '0;
		length_bytes <= '0;
		timestamp    <= '0;
		bin_index    <= '0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		program_window(BEGIN_W'(RESET_BEGIN), 1'b0, WMIN_W'(RESET_WINDOW));

		// directed: empty bins, zero length, block spans, a non-write, size and range limits
		send_request(read_item(0));
		send_request(read_item(BINIDX_W'(HIST_BINS - 1)));
		send_request(write_item(0, 0));
		send_request(write_item(1, 0));
		send_request(write_item(0, LEN_W'(BLK_BYTES)));
		send_request(write_item(OFF_W'(BLK_BYTES - 1), 2));
		r = write_item(OFF_W'(2 * BLK_BYTES), 100);
		r.is_write = 1'b0;
		send_request(r);
		send_request(write_item(0, LEN_W'(MAX_REQ_BLOCKS * BLK_BYTES)));
		send_request(write_item(OFF_W'(BLK_BYTES / 2), LEN_W'(MAX_REQ_BLOCKS * BLK_BYTES)));
		send_request(write_item(0, LEN_W'(MAX_REQ_BLOCKS * BLK_BYTES + 1)));
		send_request(write_item('1, '1));
		send_request(write_item('1, 1));
		send_request(write_item('1, 2));
		send_request(write_item(OFF_W'((NUM_BLOCKS - 1) * BLK_BYTES), LEN_W'(BLK_BYTES)));
		r = write_item(OFF_W'(3 * BLK_BYTES), LEN_W'(BLK_BYTES));
		r.ts = '1;
		send_request(r);
		r.ts = '0;
		send_request(r);
		r = write_item('1, '1);
		r.cmd = CMD_READ_BIN;
		r.bin = 0;
		send_request(r);
		send_request(read_item(1));
		send_request(read_item('1));
		wait_until_drained();

		run_phase(180, 1'b0);

		program_window(BEGIN_W'(RESET_BEGIN + $urandom_range(0, 1000000)), 1'b1,
			WMIN_W'($urandom_range(1, 300)));
		run_phase(80, 1'b1);

		calm = 1'b1;
		program_window('0, 1'b1, '1);
		run_phase(40, 1'b1);
		calm = 1'b0;

		program_window(BEGIN_W'(LAST_MINUTE), 1'b1, 1);
		run_phase(30, 1'b1);

		// window of zero length: every request is skipped
		program_window('1, 1'b1, '0);
		run_phase(15, 1'b1);

		program_window(BEGIN_W'(RESET_BEGIN), 1'b0, WMIN_W'(RESET_WINDOW));
		run_phase(60, 1'b0);

		repeat (40) @(posedge clk);
		if (tracker.failures == 0)
			$display("write_reuse_distance_histogram_test passed");
		else
			$display("write_reuse_distance_histogram_test failed");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("write_reuse_distance_histogram_test failed");
		$finish;
	end

endmodule

// ===== write_reuse_distance_histogram.f =====
+incdir+sv
sv/wrdh_pkg.sv
sv/wrdh_window.sv
sv/wrdh_lastwr.sv
sv/wrdh_hist.sv
sv/write_reuse_distance_histogram.sv
tb/write_reuse_distance_histogram_test.sv
